@@ hw/rtl/cht_pkg.sv @@
package cht_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_SEARCH = 2'd2;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [30:0] key;
    logic [31:0] value_in;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [31:0] value_out;
  } out_t;

endpackage

@@ hw/rtl/cht_front.sv @@
module cht_front #(
  parameter int BUCKETS = 10,
  parameter int BW      = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  cht_pkg::in_t  in_data,
  output logic          q_push,
  input  logic          q_full,
  output cht_pkg::in_t  q_item,
  output logic [BW-1:0] q_bucket
);

  // quotient estimate floor(key * MUL_C / 2^SHIFT) is exact or low by one,
  // so the first remainder is below 2*BUCKETS and one subtract finishes it
  localparam int              SHIFT = 31 + $clog2(BUCKETS + 1) - 1;
  localparam longint unsigned MUL_L = (64'd1 << SHIFT) / BUCKETS;
  localparam logic [31:0]     MUL_C = 32'(MUL_L);
  localparam int              RW    = BW + 1;
  localparam int              STEPS = 3;

  logic          busy_r;
  cht_pkg::in_t  item_r;
  logic [62:0]   prod_r, prod_nxt;
  logic [RW-1:0] est_r, est_nxt;
  logic [BW-1:0] rem_r, rem_nxt;
  logic [1:0]    cnt_r;
  logic          done;

  assign in_ready = !busy_r;
  assign done     = (cnt_r == 2'(STEPS));
  assign q_push   = busy_r && done && !q_full;
  assign q_item   = item_r;
  assign q_bucket = rem_r;

  always_comb begin
    logic [30:0] quot;
    logic [39:0] qb;
    logic [30:0] diff;
    prod_nxt = 63'(item_r.key) * 63'(MUL_C);
    quot     = 31'(prod_r >> SHIFT);
    qb       = 40'(quot) * 40'(BUCKETS);
    diff     = item_r.key - qb[30:0];
    est_nxt  = diff[RW-1:0];
    if (est_r >= RW'(BUCKETS)) rem_nxt = BW'(est_r - RW'(BUCKETS));
    else rem_nxt = est_r[BW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (!busy_r) begin
      if (in_valid) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        item_r <= in_data;
      end
    end else if (!done) begin
      cnt_r  <= cnt_r + 2'd1;
      prod_r <= prod_nxt;
      est_r  <= est_nxt;
      rem_r  <= rem_nxt;
    end else if (!q_full) begin
      busy_r <= 1'b0;
    end
  end

endmodule

@@ hw/rtl/cht_queue.sv @@
module cht_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         not_empty,
  output logic [W-1:0] pop_data
);

  logic [W-1:0] slot_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign pop_data  = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        slot_r[wp_r] <= push_data;
        wp_r         <= !wp_r;
      end
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ hw/rtl/cht_back.sv @@
module cht_back #(
  parameter int BUCKETS = 10,
  parameter int POOL    = 64,
  parameter int BW      = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_pop,
  input  cht_pkg::in_t  q_item,
  input  logic [BW-1:0] q_bucket,
  output logic          out_valid,
  input  logic          out_ready,
  output cht_pkg::out_t out_data
);

  localparam int PIW  = (POOL > 1) ? $clog2(POOL) : 1;
  localparam int PW   = $clog2(POOL + 1);
  localparam int MAXN = (POOL > BUCKETS) ? POOL : BUCKETS;
  localparam int CW   = $clog2(MAXN);
  localparam logic [PW-1:0] NIL = PW'(POOL);

  typedef enum logic [9:0] {
    S_CLR  = 10'b0000000001,
    S_IDLE = 10'b0000000010,
    S_HEAD = 10'b0000000100,
    S_WALK = 10'b0000001000,
    S_CHK  = 10'b0000010000,
    S_INS1 = 10'b0000100000,
    S_INS2 = 10'b0001000000,
    S_INS3 = 10'b0010000000,
    S_DEL1 = 10'b0100000000,
    S_DEL2 = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [30:0]   keys_mem  [POOL];
  logic [31:0]   vals_mem  [POOL];
  logic [PW-1:0] links_mem [POOL];
  logic [PW-1:0] heads_mem [BUCKETS];

  logic [30:0]   key_rd_r;
  logic [31:0]   val_rd_r;
  logic [PW-1:0] link_rd_r, head_rd_r;

  logic [PIW-1:0] ent_ra;
  logic [BW-1:0]  head_ra;

  logic           ent_we, link_we, head_we;
  logic [PIW-1:0] ent_wa, link_wa;
  logic [PW-1:0]  link_wd, head_wd;
  logic [BW-1:0]  head_wa;

  cht_pkg::in_t   item_r;
  logic [BW-1:0]  bkt_r;
  logic [PW-1:0]  cur_r, cur_nxt, prev_r, prev_nxt, nxt_r, nxt_nxt;
  logic [PW-1:0]  free_r, free_nxt, ins_e_r, ins_e_nxt;
  logic [CW-1:0]  clr_r;
  logic           out_valid_r;
  cht_pkg::out_t  out_r;
  logic           finish;
  cht_pkg::out_t  res;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    prev_nxt  = prev_r;
    nxt_nxt   = nxt_r;
    free_nxt  = free_r;
    ins_e_nxt = ins_e_r;
    q_pop     = 1'b0;
    finish    = 1'b0;
    res       = '{status: cht_pkg::ST_DONE, found: 1'b0, value_out: 32'd0};
    ent_ra    = cur_r[PIW-1:0];
    head_ra   = q_bucket;
    ent_we    = 1'b0;
    ent_wa    = free_r[PIW-1:0];
    link_we   = 1'b0;
    link_wa   = cur_r[PIW-1:0];
    link_wd   = cur_r;
    head_we   = 1'b0;
    head_wa   = bkt_r;
    head_wd   = cur_r;

    unique case (state_r)
      S_CLR: begin
        link_we = (32'(clr_r) < POOL);
        link_wa = clr_r[PIW-1:0];
        link_wd = PW'(clr_r) + PW'(1);
        head_we = (32'(clr_r) < BUCKETS);
        head_wa = clr_r[BW-1:0];
        head_wd = NIL;
        if (clr_r == CW'(MAXN - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (q_valid && !out_valid_r) begin
          q_pop     = 1'b1;
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        cur_nxt  = head_rd_r;
        prev_nxt = NIL;
        if (item_r.cmd == cht_pkg::CMD_INSERT && free_r == NIL) begin
          res.status = cht_pkg::ST_FULL;
          finish     = 1'b1;
        end else if (item_r.cmd == cht_pkg::CMD_INSERT || item_r.cmd == cht_pkg::CMD_DELETE ||
                     item_r.cmd == cht_pkg::CMD_SEARCH) begin
          state_nxt = S_WALK;
        end else begin
          finish = 1'b1;
        end
      end
      S_WALK: begin
        if (cur_r != NIL) begin
          state_nxt = S_CHK;
        end else if (item_r.cmd == cht_pkg::CMD_INSERT) begin
          state_nxt = S_INS1;
        end else begin
          res.status = cht_pkg::ST_MISS;
          finish     = 1'b1;
        end
      end
      S_CHK: begin
        if (item_r.cmd == cht_pkg::CMD_INSERT) begin
          if (key_rd_r < item_r.key) begin
            prev_nxt  = cur_r;
            cur_nxt   = link_rd_r;
            state_nxt = S_WALK;
          end else begin
            state_nxt = S_INS1;
          end
        end else if (key_rd_r == item_r.key) begin
          if (item_r.cmd == cht_pkg::CMD_SEARCH) begin
            res.found     = 1'b1;
            res.value_out = val_rd_r;
            finish        = 1'b1;
          end else begin
            nxt_nxt   = link_rd_r;
            state_nxt = S_DEL1;
          end
        end else begin
          prev_nxt  = cur_r;
          cur_nxt   = link_rd_r;
          state_nxt = S_WALK;
        end
      end
      S_INS1: begin
        ent_ra    = free_r[PIW-1:0];
        state_nxt = S_INS2;
      end
      S_INS2: begin
        ent_we    = 1'b1;
        link_we   = 1'b1;
        link_wa   = free_r[PIW-1:0];
        link_wd   = cur_r;
        free_nxt  = link_rd_r;
        ins_e_nxt = free_r;
        if (prev_r == NIL) begin
          head_we = 1'b1;
          head_wd = free_r;
          finish  = 1'b1;
        end else begin
          state_nxt = S_INS3;
        end
      end
      S_INS3: begin
        link_we = 1'b1;
        link_wa = prev_r[PIW-1:0];
        link_wd = ins_e_r;
        finish  = 1'b1;
      end
      S_DEL1: begin
        if (prev_r == NIL) begin
          head_we = 1'b1;
          head_wd = nxt_r;
        end else begin
          link_we = 1'b1;
          link_wa = prev_r[PIW-1:0];
          link_wd = nxt_r;
        end
        state_nxt = S_DEL2;
      end
      S_DEL2: begin
        link_we   = 1'b1;
        link_wa   = cur_r[PIW-1:0];
        link_wd   = free_r;
        free_nxt  = cur_r;
        res.found = 1'b1;
        finish    = 1'b1;
      end
      default: state_nxt = S_CLR;
    endcase
    if (finish) state_nxt = S_IDLE;
  end

  // node pool and bucket head memories
  always_ff @(posedge clk) begin
    key_rd_r  <= keys_mem[ent_ra];
    val_rd_r  <= vals_mem[ent_ra];
    link_rd_r <= links_mem[ent_ra];
    head_rd_r <= heads_mem[head_ra];
    if (ent_we) begin
      keys_mem[ent_wa] <= item_r.key;
      vals_mem[ent_wa] <= item_r.value_in;
    end
    if (link_we) links_mem[link_wa] <= link_wd;
    if (head_we) heads_mem[head_wa] <= head_wd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      free_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      free_r  <= free_nxt;
      if (state_r == S_CLR) clr_r <= clr_r + CW'(1);
      if (finish) begin
        out_valid_r <= 1'b1;
        out_r       <= res;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    prev_r  <= prev_nxt;
    nxt_r   <= nxt_nxt;
    ins_e_r <= ins_e_nxt;
    if (q_pop) begin
      item_r <= q_item;
      bkt_r  <= q_bucket;
    end
  end

endmodule

@@ hw/rtl/chained_hash_table_unit.sv @@
// Chained hash table over a fixed node pool. Each input transaction is an insert, delete or
// search; exactly one result transaction follows each, in order. The front stage works out
// the bucket (key mod BUCKETS) by reciprocal multiplication through the prod, est and rem
// registers, and hands the item through a two-entry queue to the back stage, which walks the
// bucket chain one node at a time, a head or link read then a key check, on pool memories with
// one read port and one write port; insert and delete then finish with link and head writes.
// After reset the back stage runs a clearing pass to build the free list and null the bucket
// heads; items are queued but not executed until it finishes.
module chained_hash_table_unit #(
  parameter int BUCKETS = 10,
  parameter int POOL    = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  cht_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output cht_pkg::out_t out_data
);

  localparam int BW = $clog2(BUCKETS);
  localparam int QW = $bits(cht_pkg::in_t) + BW;

  logic          q_push, q_full, q_pop, q_valid;
  cht_pkg::in_t  f_item, b_item;
  logic [BW-1:0] f_bucket, b_bucket;
  logic [QW-1:0] q_out;

  cht_front #(.BUCKETS(BUCKETS), .BW(BW)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_full   (q_full),
    .q_item   (f_item),
    .q_bucket (f_bucket)
  );

  cht_queue #(.W(QW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({f_item, f_bucket}),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_out)
  );

  assign b_item   = cht_pkg::in_t'(q_out[QW-1:BW]);
  assign b_bucket = q_out[BW-1:0];

  cht_back #(.BUCKETS(BUCKETS), .POOL(POOL), .BW(BW)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (b_item),
    .q_bucket  (b_bucket),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
